// ===== src/rbb_pkg.sv =====
package rbb_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int RADIUS_W   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 2'd3;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET = 6'd50;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ZRD,
    ST_ZADD,
    ST_CRD,
    ST_CSUB,
    ST_CADD,
    ST_CWR,
    ST_SRD,
    ST_SSUB,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } rbb_state_t;

endpackage

// ===== src/rbb_in_if.sv =====
interface rbb_in_if import rbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;

  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

// ===== src/rbb_out_if.sv =====
interface rbb_out_if import rbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic             frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ===== src/rbb_cfg_if.sv =====
interface rbb_cfg_if import rbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rgb_box_blur_clipped.sv =====
// Clipped RGB box blur: each output pixel is the truncated per-channel mean
// of the (2r+1)x(2r+1) window around it, clipped to the frame.
// in_ch carries one transaction per item: kind 0 is a pixel in raster order,
// kind 1 a drain tick. Each item yields at most one result on out_ch, in
// raster order, once the window of the next output is complete; drain ticks
// (and pixels past the end of the frame) release the remaining outputs.
// frame_last marks the final output; the block then starts a new frame.
// cfg_ch writes frame_width, frame_height and blur_radius (index 0..2); a
// write to one of them restarts the frame. Write only while the block is idle.
// Sequencing: items are handled one at a time by a sequencer around two
// single-port-read RAMs (pixel ring and column sums). A plain item runs,
// from one accept to the next: accept, check, one column update, one column
// retire, divider setup and 8 divider steps, emit. An item whose window is
// not complete yet is only accepted and checked. The first output of a row
// rebuilds rx+1 columns by column updates, or on the top row by summing
// rows 0..min(r,h-1) of each column. The result shows on out_ch in the cycle after emit.
// The result register lets a new transaction in while a result waits; the
// sequencer holds in emit until out_ch takes the previous one.
// Reset (rst_n low, synchronous) loads 640x480, radius 50, and empties the
// frame; no memory clearing pass is needed.
module rgb_box_blur_clipped import rbb_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 63
) (
  input  logic     clk,
  input  logic     rst_n,
  rbb_in_if.sink   in_ch,
  rbb_out_if.source out_ch,
  rbb_cfg_if.sink  cfg_ch
);

  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int R_W    = $clog2(MAX_RADIUS + 1);
  localparam int YW     = ((ROW_W > R_W) ? ROW_W : R_W) + 1;
  localparam int XW     = ((COL_W > R_W) ? COL_W : R_W) + 1;
  localparam int RING   = 2 * MAX_RADIUS + 3;
  localparam int RING_W = $clog2(RING);
  localparam int ADDR_W = $clog2(RING * MAX_WIDTH);
  localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int CS_W   = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int WS_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int CNT_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int DV_W   = WS_W + PIX_W;

  rbb_state_t state_r, state_nxt;

  // configuration
  logic [CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  logic [RADIUS_W-1:0]   blur_radius_r;

  // frame position
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [RING_W-1:0] in_ring_r, out_ring_r;

  // datapath
  logic [CS_W-1:0]   acc_r [3];
  logic [WS_W-1:0]   rws_r [3];
  logic [WS_W-1:0]   rem_r [3];
  logic [PIX_W-1:0]  quo_r [3];
  logic [X_W-1:0]    x_r, rx_r;
  logic [R_W-1:0]    y_r;
  logic [SPAN_W-1:0] dy_r, dx_r;
  logic [CNT_W-1:0]  count_r;
  logic [2:0]        bit_r;
  logic              last_r;

  // result register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic             out_last_r;

  // effective settings and derived window terms
  logic [COL_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [R_W-1:0]    r_eff;
  logic [YW-1:0]     h_m1, oy_w, ry_w, oy_pr, ry, y0;
  logic [XW-1:0]     w_m1, ox_w, rx_w, ox_pr, rx, x0, ox_mr;
  logic [SPAN_W-1:0] dy, dx;
  logic              win_ready, frame_bad, is_last;
  logic              sub_row_ok, add_row_ok, add_col_ok, sub_col_ok;
  logic [X_W-1:0]    add_col, sub_col;
  logic [R_W-1:0]    z_last;
  logic [RING_W:0]   add_ring_s, sub_ring_s;
  logic [RING_W-1:0] add_ring, sub_ring;
  logic [RING_W-1:0] in_ring_nxt, out_ring_nxt;

  // handshakes
  logic in_acc, cfg_acc, cfg_hit, out_acc, emit_go, px_store, restart;

  // memory ports
  logic                row_we;
  logic [ADDR_W-1:0]   row_waddr, row_raddr;
  logic [3*PIX_W-1:0]  row_wdata, row_rdata;
  logic                col_we;
  logic [X_W-1:0]      col_waddr, col_raddr;
  logic [3*CS_W-1:0]   col_wdata, col_rdata;

  function automatic logic [ADDR_W-1:0] row_addr(input logic [RING_W-1:0] ring,
                                                  input logic [X_W-1:0] col);
    row_addr = ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = COL_W'(1);
    end else if (frame_width_r > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (frame_height_r > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(frame_height_r);
    end
    if (blur_radius_r > MAX_RADIUS) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(blur_radius_r);
    end
  end

  always_comb begin
    h_m1  = YW'(h_eff) - YW'(1);
    w_m1  = XW'(w_eff) - XW'(1);
    oy_w  = YW'(out_row_r);
    ox_w  = XW'(out_col_r);
    ry_w  = YW'(r_eff);
    rx_w  = XW'(r_eff);
    oy_pr = oy_w + ry_w;
    ox_pr = ox_w + rx_w;
    ox_mr = ox_w - rx_w - XW'(1);
    ry    = (oy_pr <= h_m1) ? oy_pr : h_m1;
    rx    = (ox_pr <= w_m1) ? ox_pr : w_m1;
    y0    = (oy_w > ry_w) ? (oy_w - ry_w) : '0;
    x0    = (ox_w > rx_w) ? (ox_w - rx_w) : '0;
    dy    = SPAN_W'(ry - y0 + YW'(1));
    dx    = SPAN_W'(rx - x0 + XW'(1));
    win_ready = (YW'(in_row_r) > ry) ||
                ((YW'(in_row_r) == ry) && (XW'(in_col_r) > rx));
    frame_bad  = (out_row_r >= h_eff) || (out_col_r >= w_eff);
    is_last    = (oy_w == h_m1) && (ox_w == w_m1);
    sub_row_ok = oy_w >= ry_w + YW'(1);
    add_row_ok = oy_pr < YW'(h_eff);
    add_col_ok = ox_pr < XW'(w_eff);
    sub_col_ok = ox_w >= rx_w + XW'(1);
    add_col    = ox_pr[X_W-1:0];
    sub_col    = ox_mr[X_W-1:0];
    z_last     = (ry_w <= h_m1) ? r_eff : R_W'(h_m1);
    // ring rows of (oy + r) and (oy - 1 - r)
    add_ring_s = (RING_W+1)'(out_ring_r) + (RING_W+1)'(r_eff);
    sub_ring_s = (RING_W+1)'(out_ring_r) + (RING_W+1)'(RING - 1) - (RING_W+1)'(r_eff);
    add_ring   = (add_ring_s >= (RING_W+1)'(RING)) ?
                 RING_W'(add_ring_s - (RING_W+1)'(RING)) : RING_W'(add_ring_s);
    sub_ring   = (sub_ring_s >= (RING_W+1)'(RING)) ?
                 RING_W'(sub_ring_s - (RING_W+1)'(RING)) : RING_W'(sub_ring_s);
    in_ring_nxt  = (in_ring_r == RING_W'(RING - 1)) ? '0 : in_ring_r + RING_W'(1);
    out_ring_nxt = (out_ring_r == RING_W'(RING - 1)) ? '0 : out_ring_r + RING_W'(1);
  end

  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  // only a write to a defined register ends the frame
  assign cfg_hit  = cfg_acc && ((cfg_ch.index == REG_FRAME_WIDTH) ||
                                (cfg_ch.index == REG_FRAME_HEIGHT) ||
                                (cfg_ch.index == REG_BLUR_RADIUS));
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign px_store = in_acc && (in_ch.kind == KIND_PIXEL) && (in_row_r < h_eff);
  assign restart  = cfg_hit || ((state_r == ST_CHECK) && frame_bad) ||
                    (emit_go && last_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (frame_bad || !win_ready) begin
          state_nxt = ST_IDLE;
        end else if (out_col_r == '0 || add_col_ok) begin
          state_nxt = (out_row_r == '0) ? ST_ZRD : ST_CRD;
        end else if (sub_col_ok) begin
          state_nxt = ST_SRD;
        end else begin
          state_nxt = ST_DINIT;
        end
      end
      ST_ZRD:  state_nxt = ST_ZADD;
      ST_ZADD: state_nxt = (y_r == z_last) ? ST_CWR : ST_ZRD;
      ST_CRD:  state_nxt = ST_CSUB;
      ST_CSUB: state_nxt = ST_CADD;
      ST_CADD: state_nxt = ST_CWR;
      ST_CWR: begin
        if (out_col_r == '0) begin
          if (x_r == rx_r) begin
            state_nxt = ST_DINIT;
          end else begin
            state_nxt = (out_row_r == '0) ? ST_ZRD : ST_CRD;
          end
        end else begin
          state_nxt = sub_col_ok ? ST_SRD : ST_DINIT;
        end
      end
      ST_SRD:   state_nxt = ST_SSUB;
      ST_SSUB:  state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (bit_r == '0) ? ST_EMIT : ST_DIV;
      ST_EMIT:  state_nxt = emit_go ? ST_IDLE : ST_EMIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory controls
  always_comb begin
    in_ch.ready = 1'b0;
    row_raddr   = '0;
    col_raddr   = '0;
    col_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_ZRD:  row_raddr = row_addr(RING_W'(y_r), x_r);
      ST_CRD: begin
        row_raddr = row_addr(sub_ring, x_r);
        col_raddr = x_r;
      end
      ST_CSUB: row_raddr = row_addr(add_ring, x_r);
      ST_CWR:  col_we = 1'b1;
      ST_SRD:  col_raddr = sub_col;
      default: in_ch.ready = 1'b0;
    endcase
  end

  assign cfg_ch.ready = 1'b1;
  assign row_we    = px_store;
  assign row_waddr = row_addr(in_ring_r, in_col_r[X_W-1:0]);
  assign row_wdata = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
  assign col_waddr = x_r;
  assign col_wdata = {acc_r[2], acc_r[1], acc_r[0]};

  rbb_ram #(.WIDTH(3 * PIX_W), .DEPTH(RING * MAX_WIDTH)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  rbb_ram #(.WIDTH(3 * CS_W), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
      blur_radius_r  <= RADIUS_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      in_ring_r      <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      out_ring_r     <= '0;
      out_valid_r    <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        rws_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data;
          REG_BLUR_RADIUS:  blur_radius_r  <= cfg_ch.data[RADIUS_W-1:0];
          default: ;
        endcase
      end
      // advance the write position on each stored pixel
      if (px_store) begin
        if (in_col_r + COL_W'(1) >= w_eff) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + ROW_W'(1);
          in_ring_r <= in_ring_nxt;
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
      // running window sum: clear at a row start, add entered columns,
      // drop the column that leaves on the left
      if (state_r == ST_CHECK && out_col_r == '0) begin
        for (int c = 0; c < 3; c++) begin
          rws_r[c] <= '0;
        end
      end else if (state_r == ST_CWR) begin
        for (int c = 0; c < 3; c++) begin
          rws_r[c] <= rws_r[c] + WS_W'(acc_r[c]);
        end
      end else if (state_r == ST_SSUB) begin
        for (int c = 0; c < 3; c++) begin
          rws_r[c] <= rws_r[c] - WS_W'(col_rdata[c*CS_W +: CS_W]);
        end
      end
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        if (out_col_r + COL_W'(1) >= w_eff) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + ROW_W'(1);
          out_ring_r <= out_ring_nxt;
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
      if (restart) begin
        in_col_r   <= '0;
        in_row_r   <= '0;
        in_ring_r  <= '0;
        out_col_r  <= '0;
        out_row_r  <= '0;
        out_ring_r <= '0;
        for (int c = 0; c < 3; c++) begin
          rws_r[c] <= '0;
        end
      end
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CHECK: begin
        dy_r   <= dy;
        dx_r   <= dx;
        rx_r   <= rx[X_W-1:0];
        last_r <= is_last;
        x_r    <= (out_col_r == '0) ? '0 : add_col;
        y_r    <= '0;
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= '0;
        end
      end
      ST_ZADD: begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= acc_r[c] + CS_W'(row_rdata[c*PIX_W +: PIX_W]);
        end
        y_r <= y_r + R_W'(1);
      end
      ST_CSUB: begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= col_rdata[c*CS_W +: CS_W] -
                      (sub_row_ok ? CS_W'(row_rdata[c*PIX_W +: PIX_W]) : '0);
        end
      end
      ST_CADD: begin
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= acc_r[c] +
                      (add_row_ok ? CS_W'(row_rdata[c*PIX_W +: PIX_W]) : '0);
        end
      end
      ST_CWR: begin
        // step to the next column of a row rebuild
        x_r <= x_r + X_W'(1);
        y_r <= '0;
        for (int c = 0; c < 3; c++) begin
          acc_r[c] <= '0;
        end
      end
      ST_DINIT: begin
        count_r <= CNT_W'(dy_r * dx_r);
        bit_r   <= 3'd7;
        for (int c = 0; c < 3; c++) begin
          rem_r[c] <= rws_r[c];
          quo_r[c] <= '0;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        for (int c = 0; c < 3; c++) begin
          if (DV_W'(rem_r[c]) >= (DV_W'(count_r) << bit_r)) begin
            rem_r[c]        <= WS_W'(DV_W'(rem_r[c]) - (DV_W'(count_r) << bit_r));
            quo_r[c][bit_r] <= 1'b1;
          end
        end
        bit_r <= bit_r - 3'd1;
      end
      default: ;
    endcase
    if (emit_go) begin
      out_red_r   <= quo_r[0];
      out_green_r <= quo_r[1];
      out_blue_r  <= quo_r[2];
      out_last_r  <= last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = out_red_r;
  assign out_ch.green_out  = out_green_r;
  assign out_ch.blue_out   = out_blue_r;
  assign out_ch.frame_last = out_last_r;

endmodule

// ===== src/rbb_ram.sv =====
module rbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
